// ===== rtl/gbpe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbpe_pkg
// Shared types and constants for the glyph bitmap pixel expander.
// ----------------------------------------------------------------------------
package gbpe_pkg;

  localparam int COORD_BITS = 12;
  localparam int END_BITS   = COORD_BITS + 1;
  localparam int PITCH_BITS = 9;
  localparam int LINE_BITS  = 15;
  localparam int DEPTH_BITS = 6;
  localparam int COLOR_BITS = 32;
  localparam int OFF_BITS   = 26;
  localparam int CNT_BITS   = 3;
  localparam int STAT_BITS  = 2;
  localparam int PIX_PER_BYTE = 8;
  localparam int NPIX_BITS  = 4;
  localparam int CFG_IDX_BITS = 2;

  // input commands
  localparam logic CMD_HEADER = 1'b0;
  localparam logic CMD_DATA   = 1'b1;

  // result status codes
  localparam logic [STAT_BITS-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_BITS-1:0] ST_BAD_GLYPH = 2'd1;
  localparam logic [STAT_BITS-1:0] ST_BAD_FRAME = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_LINE_BYTES  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_DEPTH = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_FORE_COLOR  = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_BACK_COLOR  = 2'd3;

  // supported framebuffer depths
  localparam logic [DEPTH_BITS-1:0] FD_8  = 6'd8;
  localparam logic [DEPTH_BITS-1:0] FD_16 = 6'd16;
  localparam logic [DEPTH_BITS-1:0] FD_32 = 6'd32;

  // supported glyph depths
  localparam logic [7:0] SD_MONO = 8'd1;
  localparam logic [7:0] SD_GRAY = 8'd8;

  typedef struct packed {
    logic                  command;
    logic [COORD_BITS-1:0] box_left;
    logic [COORD_BITS-1:0] box_top;
    logic [END_BITS-1:0]   box_right_end;
    logic [END_BITS-1:0]   box_bottom_end;
    logic [PITCH_BITS-1:0] row_pitch;
    logic [7:0]            source_depth;
    logic [7:0]            bitmap_byte;
  } in_item_t;

  typedef struct packed {
    logic [OFF_BITS-1:0]   byte_offset;
    logic [COLOR_BITS-1:0] write_data;
    logic [CNT_BITS-1:0]   byte_count;
    logic [STAT_BITS-1:0]  status;
    logic                  last;
  } out_item_t;

  typedef struct packed {
    logic [LINE_BITS-1:0]  line_bytes;
    logic [DEPTH_BITS-1:0] frame_depth;
    logic [COLOR_BITS-1:0] fore_color;
    logic [COLOR_BITS-1:0] back_color;
  } cfg_t;

  // one unit of work for the back part: a run of pixels or an error answer
  typedef struct packed {
    logic [STAT_BITS-1:0]  status;
    logic [END_BITS-1:0]   x;
    logic [END_BITS-1:0]   y;
    logic [NPIX_BITS-1:0]  count;
    logic [7:0]            bits;
    logic                  gray;
  } job_t;

  function automatic logic depth_ok(input logic [DEPTH_BITS-1:0] d);
    return (d == FD_8) || (d == FD_16) || (d == FD_32);
  endfunction

endpackage

// ===== rtl/glyph_bitmap_pixel_expander_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_bitmap_pixel_expander_unit
// Expands glyph bitmaps into framebuffer pixel writes.
// ----------------------------------------------------------------------------
// A header item yields nothing, or one status result for a bad glyph depth.
// Each data byte is taken by the front end and any job it makes is queued;
// the pixel walker then emits its writes one per cycle while the output queue
// has room, so a 1-bit source byte gives up to eight writes and an 8-bit
// source byte one. The pixel walker sets the sustained rate; each write
// passes stage 1, stage 2 and the output queue in turn. Configuration writes
// take effect at once and must only be made while no item is in flight.
module glyph_bitmap_pixel_expander_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_push,
  output logic                                 in_full,
  input  gbpe_pkg::in_item_t                   in_item,
  output logic                                 out_empty,
  input  logic                                 out_pop,
  output gbpe_pkg::out_item_t                  out_item,
  input  logic                                 cfg_we,
  input  logic [gbpe_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [gbpe_pkg::COLOR_BITS-1:0]      cfg_data
);

  gbpe_pkg::cfg_t cfg_r;
  logic           accept;
  logic           job_push;
  gbpe_pkg::job_t job_in;
  logic           job_pop;
  logic           job_full;
  logic           job_empty;
  gbpe_pkg::job_t job_head;

  assign accept  = in_push && !job_full;
  assign in_full = job_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.line_bytes  <= gbpe_pkg::LINE_BITS'(1600);
      cfg_r.frame_depth <= gbpe_pkg::FD_16;
      cfg_r.fore_color  <= 32'h00FF_FFFF;
      cfg_r.back_color  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        gbpe_pkg::REG_LINE_BYTES:  cfg_r.line_bytes  <= cfg_data[gbpe_pkg::LINE_BITS-1:0];
        gbpe_pkg::REG_FRAME_DEPTH: cfg_r.frame_depth <= cfg_data[gbpe_pkg::DEPTH_BITS-1:0];
        gbpe_pkg::REG_FORE_COLOR:  cfg_r.fore_color  <= cfg_data;
        gbpe_pkg::REG_BACK_COLOR:  cfg_r.back_color  <= cfg_data;
        default: ;
      endcase
    end
  end

  gbpe_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .item     (in_item),
    .cfg      (cfg_r),
    .job_push (job_push),
    .job      (job_in)
  );

  gbpe_job_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (job_in),
    .pop      (job_pop),
    .full     (job_full),
    .empty    (job_empty),
    .head     (job_head)
  );

  gbpe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .job_empty (job_empty),
    .job_head  (job_head),
    .job_pop   (job_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

// ===== rtl/gbpe_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbpe_front
// Takes header and data items, keeps the glyph cursor and turns each data
// byte in the box into a pixel run job (or an error job) for the back part.
// ----------------------------------------------------------------------------
module gbpe_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  gbpe_pkg::in_item_t   item,
  input  gbpe_pkg::cfg_t       cfg,
  output logic                 job_push,
  output gbpe_pkg::job_t       job
);

  logic [gbpe_pkg::COORD_BITS-1:0] left_r, left_nxt;
  logic [gbpe_pkg::END_BITS-1:0]   right_r, right_nxt;
  logic [gbpe_pkg::END_BITS-1:0]   bottom_r, bottom_nxt;
  logic [gbpe_pkg::PITCH_BITS-1:0] pitch_r, pitch_nxt;
  logic                            gray_r, gray_nxt;
  logic                            active_r, active_nxt;
  logic [gbpe_pkg::END_BITS-1:0]   cx_r, cx_nxt;
  logic [gbpe_pkg::END_BITS-1:0]   cy_r, cy_nxt;
  logic [gbpe_pkg::PITCH_BITS-1:0] rbi_r, rbi_nxt;

  logic                            in_row;
  logic [gbpe_pkg::END_BITS-1:0]   span;
  logic [gbpe_pkg::NPIX_BITS-1:0]  npix;
  logic [gbpe_pkg::END_BITS:0]     cx_inc;
  logic [gbpe_pkg::END_BITS:0]     cy_inc;
  logic [gbpe_pkg::PITCH_BITS:0]   rbi_inc;
  logic                            row_done;

  always_comb begin
    in_row  = cx_r < right_r;
    span    = right_r - cx_r;
    npix    = (span >= gbpe_pkg::END_BITS'(gbpe_pkg::PIX_PER_BYTE)) ?
              gbpe_pkg::NPIX_BITS'(gbpe_pkg::PIX_PER_BYTE) :
              span[gbpe_pkg::NPIX_BITS-1:0];
    if (!in_row) begin
      npix = '0;
    end
    cx_inc  = gray_r ? ({1'b0, cx_r} + 1'b1)
                     : ({1'b0, cx_r} + {{(gbpe_pkg::END_BITS+1-gbpe_pkg::NPIX_BITS){1'b0}}, npix});
    cy_inc  = {1'b0, cy_r} + 1'b1;
    rbi_inc = {1'b0, rbi_r} + 1'b1;
    row_done = gray_r ? (cx_inc >= {1'b0, right_r}) : (rbi_inc >= {1'b0, pitch_r});

    left_nxt   = left_r;
    right_nxt  = right_r;
    bottom_nxt = bottom_r;
    pitch_nxt  = pitch_r;
    gray_nxt   = gray_r;
    active_nxt = active_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    rbi_nxt    = rbi_r;
    job_push   = 1'b0;
    job        = '0;

    if (accept) begin
      if (item.command == gbpe_pkg::CMD_HEADER) begin
        left_nxt   = item.box_left;
        right_nxt  = item.box_right_end;
        bottom_nxt = item.box_bottom_end;
        pitch_nxt  = item.row_pitch;
        cx_nxt     = {1'b0, item.box_left};
        cy_nxt     = {1'b0, item.box_top};
        rbi_nxt    = '0;
        if (item.source_depth != gbpe_pkg::SD_MONO && item.source_depth != gbpe_pkg::SD_GRAY) begin
          active_nxt = 1'b0;
          job_push   = 1'b1;
          job.status = gbpe_pkg::ST_BAD_GLYPH;
        end else begin
          gray_nxt   = (item.source_depth == gbpe_pkg::SD_GRAY);
          active_nxt = (item.box_right_end > {1'b0, item.box_left}) &&
                       (item.box_bottom_end > {1'b0, item.box_top});
        end
      end else if (active_r) begin
        if ((gray_r || in_row) && !gbpe_pkg::depth_ok(cfg.frame_depth)) begin
          active_nxt = 1'b0;
          job_push   = 1'b1;
          job.status = gbpe_pkg::ST_BAD_FRAME;
        end else begin
          job.status = gbpe_pkg::ST_OK;
          job.x      = cx_r;
          job.y      = cy_r;
          job.count  = gray_r ? gbpe_pkg::NPIX_BITS'(1) : npix;
          job.bits   = item.bitmap_byte;
          job.gray   = gray_r;
          job_push   = gray_r || in_row;
          cx_nxt     = cx_inc[gbpe_pkg::END_BITS-1:0];
          rbi_nxt    = rbi_inc[gbpe_pkg::PITCH_BITS-1:0];
          if (row_done) begin
            cy_nxt  = cy_inc[gbpe_pkg::END_BITS-1:0];
            cx_nxt  = {1'b0, left_r};
            rbi_nxt = '0;
            if (cy_inc >= {1'b0, bottom_r}) begin
              active_nxt = 1'b0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= '0;
      right_r  <= '0;
      bottom_r <= '0;
      pitch_r  <= '0;
      gray_r   <= 1'b0;
      active_r <= 1'b0;
      cx_r     <= '0;
      cy_r     <= '0;
      rbi_r    <= '0;
    end else begin
      left_r   <= left_nxt;
      right_r  <= right_nxt;
      bottom_r <= bottom_nxt;
      pitch_r  <= pitch_nxt;
      gray_r   <= gray_nxt;
      active_r <= active_nxt;
      cx_r     <= cx_nxt;
      cy_r     <= cy_nxt;
      rbi_r    <= rbi_nxt;
    end
  end

endmodule

// ===== rtl/gbpe_job_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbpe_job_queue
// Two-entry queue of jobs between the front and back parts.
// ----------------------------------------------------------------------------
module gbpe_job_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  gbpe_pkg::job_t  push_job,
  input  logic            pop,
  output logic            full,
  output logic            empty,
  output gbpe_pkg::job_t  head
);

  gbpe_pkg::job_t slot_r [2];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== rtl/gbpe_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbpe_back
// Walks each job one pixel per cycle while the small output queue has room,
// computes address and pixel value in two stages and parks results in it.
// ----------------------------------------------------------------------------
module gbpe_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  gbpe_pkg::cfg_t        cfg,
  input  logic                  job_empty,
  input  gbpe_pkg::job_t        job_head,
  output logic                  job_pop,
  output logic                  out_empty,
  input  logic                  out_pop,
  output gbpe_pkg::out_item_t   out_item
);

  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR   = $clog2(OQ_DEPTH);
  localparam int PROD_BITS = gbpe_pkg::END_BITS + gbpe_pkg::LINE_BITS;
  localparam int XOFF_BITS = gbpe_pkg::END_BITS + 2;

  // iterator
  logic                           busy_r;
  gbpe_pkg::job_t                 job_r;
  logic [2:0]                     k_r;
  logic                           issue;
  logic                           pix_last;
  logic                           pix_fg;
  logic [gbpe_pkg::END_BITS-1:0]  pix_x;

  // stage 1
  logic                           s1_v_r;
  logic [gbpe_pkg::STAT_BITS-1:0] s1_st_r;
  logic [gbpe_pkg::END_BITS-1:0]  s1_x_r;
  logic [gbpe_pkg::END_BITS-1:0]  s1_y_r;
  logic                           s1_fg_r;
  logic                           s1_last_r;

  // stage 2
  logic                           s2_v_r;
  logic [gbpe_pkg::STAT_BITS-1:0] s2_st_r;
  logic [PROD_BITS-1:0]           s2_prod_r;
  logic [XOFF_BITS-1:0]           s2_xoff_r;
  logic [gbpe_pkg::COLOR_BITS-1:0] s2_data_r;
  logic [gbpe_pkg::CNT_BITS-1:0]  s2_cnt_r;
  logic                           s2_last_r;

  logic [gbpe_pkg::COLOR_BITS-1:0] color;
  logic [gbpe_pkg::COLOR_BITS-1:0] enc_data;
  logic [gbpe_pkg::CNT_BITS-1:0]   enc_cnt;
  logic [XOFF_BITS-1:0]            enc_xoff;

  // output queue
  gbpe_pkg::out_item_t            oq_r [OQ_DEPTH];
  logic [OQ_PTR-1:0]              oq_wp_r, oq_rp_r;
  logic [OQ_PTR:0]                oq_cnt_r;
  logic                           oq_pop;
  gbpe_pkg::out_item_t            s2_item;
  logic [PROD_BITS:0]             off_sum;

  assign oq_pop    = out_pop && (oq_cnt_r != '0);
  assign out_empty = (oq_cnt_r == '0);
  assign out_item  = oq_r[oq_rp_r];

  // leave room for everything already in the two stages
  always_comb begin
    issue    = busy_r &&
               ((oq_cnt_r + {{OQ_PTR{1'b0}}, s1_v_r} + {{OQ_PTR{1'b0}}, s2_v_r})
                < (OQ_PTR+1)'(OQ_DEPTH));
    pix_last = (job_r.status != gbpe_pkg::ST_OK) ||
               ({1'b0, k_r} == job_r.count - gbpe_pkg::NPIX_BITS'(1));
    pix_fg   = job_r.gray ? (job_r.bits != 8'd0) : job_r.bits[3'd7 - k_r];
    pix_x    = job_r.x + {{(gbpe_pkg::END_BITS-3){1'b0}}, k_r};
    job_pop  = !job_empty && (!busy_r || (issue && pix_last));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      k_r    <= '0;
    end else begin
      if (job_pop) begin
        busy_r <= 1'b1;
        k_r    <= '0;
      end else if (issue) begin
        busy_r <= !pix_last;
        k_r    <= k_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      job_r <= job_head;
    end
  end

  // pixel coding: 8-bit low byte, RGB565, or 32-bit as is
  always_comb begin
    color = s1_fg_r ? cfg.fore_color : cfg.back_color;
    case (cfg.frame_depth)
      gbpe_pkg::FD_8: begin
        enc_data = {24'd0, color[7:0]};
        enc_cnt  = 3'd1;
        enc_xoff = {2'b00, s1_x_r};
      end
      gbpe_pkg::FD_16: begin
        enc_data = {16'd0, color[23:19], color[15:10], color[7:3]};
        enc_cnt  = 3'd2;
        enc_xoff = {1'b0, s1_x_r, 1'b0};
      end
      default: begin
        enc_data = color;
        enc_cnt  = 3'd4;
        enc_xoff = {s1_x_r, 2'b00};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= issue;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_st_r   <= job_r.status;
    s1_x_r    <= pix_x;
    s1_y_r    <= job_r.y;
    s1_fg_r   <= pix_fg;
    s1_last_r <= pix_last;

    s2_st_r   <= s1_st_r;
    s2_last_r <= s1_last_r;
    if (s1_st_r == gbpe_pkg::ST_OK) begin
      s2_prod_r <= s1_y_r * cfg.line_bytes;
      s2_xoff_r <= enc_xoff;
      s2_data_r <= enc_data;
      s2_cnt_r  <= enc_cnt;
    end else begin
      s2_prod_r <= '0;
      s2_xoff_r <= '0;
      s2_data_r <= '0;
      s2_cnt_r  <= '0;
    end
  end

  always_comb begin
    off_sum             = {1'b0, s2_prod_r} + {{(PROD_BITS+1-XOFF_BITS){1'b0}}, s2_xoff_r};
    s2_item.byte_offset = off_sum[gbpe_pkg::OFF_BITS-1:0];
    s2_item.write_data  = s2_data_r;
    s2_item.byte_count  = s2_cnt_r;
    s2_item.status      = s2_st_r;
    s2_item.last        = s2_last_r;
  end

  always_ff @(posedge clk) begin
    if (s2_v_r) begin
      oq_r[oq_wp_r] <= s2_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wp_r  <= '0;
      oq_rp_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      if (s2_v_r) begin
        oq_wp_r <= oq_wp_r + 1'b1;
      end
      if (oq_pop) begin
        oq_rp_r <= oq_rp_r + 1'b1;
      end
      case ({s2_v_r, oq_pop})
        2'b10:   oq_cnt_r <= oq_cnt_r + 1'b1;
        2'b01:   oq_cnt_r <= oq_cnt_r - 1'b1;
        default: oq_cnt_r <= oq_cnt_r;
      endcase
    end
  end

endmodule

// ===== tb/tb_glyph_bitmap_pixel_expander_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_glyph_bitmap_pixel_expander_unit
// Self-checking bench for the glyph bitmap pixel expander. A short table of
// hand-picked headers, bytes and register writes runs first, then random
// glyph sequences under several framebuffer settings. Every popped result is
// checked field by field against an in-bench model or a hand-pinned value.
// ----------------------------------------------------------------------------
module tb_glyph_bitmap_pixel_expander_unit;
  import gbpe_pkg::*;

  localparam int SETTLE_CYCLES   = 48;
  localparam int RAND_PHASES     = 8;
  localparam int ITEMS_PER_PHASE = 50;
  localparam int TIMEOUT_NS      = 5_000_000;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;
  typedef enum logic [1:0] {POP_ALWAYS, POP_THREE_IN_FOUR, POP_COIN, POP_STALLS} pop_mode_t;

  typedef struct {
    row_kind_t               kind;
    in_item_t                item;
    logic [CFG_IDX_BITS-1:0] reg_idx;
    logic [31:0]             reg_val;
    bit                      typed;
    out_item_t               want;
  } plan_row_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_push = 1'b0;
  logic                    in_full;
  in_item_t                in_item = '0;
  logic                    out_empty;
  logic                    out_pop = 1'b0;
  out_item_t               dut_px;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [COLOR_BITS-1:0]   cfg_data = '0;

  glyph_bitmap_pixel_expander_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_item  (in_item),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_item (dut_px),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register mirror
  logic [LINE_BITS-1:0]  cfg_line = 15'd1600;
  logic [DEPTH_BITS-1:0] cfg_depth = FD_16;
  logic [COLOR_BITS-1:0] cfg_fore = 32'h00FF_FFFF;
  logic [COLOR_BITS-1:0] cfg_back = 32'h0000_0000;

  // glyph walker state
  logic [COORD_BITS-1:0] g_left = '0;
  logic [END_BITS-1:0]   g_right = '0;
  logic [END_BITS-1:0]   g_bottom = '0;
  logic [PITCH_BITS-1:0] g_pitch = '0;
  bit                    g_gray = 1'b0;
  bit                    g_active = 1'b0;
  logic [END_BITS-1:0]   cur_x = '0;
  logic [END_BITS-1:0]   cur_y = '0;
  logic [PITCH_BITS-1:0] row_idx = '0;

  out_item_t step_px[$];
  out_item_t pending_px[$];
  out_item_t front_px;
  plan_row_t plan[$];
  in_item_t  stim_q[$];
  int        stim_live;

  int burst_left = 1;
  int items_sent = 0;
  int live_items = 0;
  int reg_writes = 0;
  int results_checked = 0;
  int fault_count = 0;
  int pop_cycle = 0;
  int stall_left = 0;
  pop_mode_t pop_mode = POP_ALWAYS;

  function automatic out_item_t answer(input logic [OFF_BITS-1:0] off,
                                       input logic [COLOR_BITS-1:0] data,
                                       input logic [CNT_BITS-1:0] cnt,
                                       input logic [STAT_BITS-1:0] st);
    out_item_t px;
    px.byte_offset = off;
    px.write_data  = data;
    px.byte_count  = cnt;
    px.status      = st;
    px.last        = 1'b1;
    return px;
  endfunction

  function automatic out_item_t pixel_word(input bit fg);
    logic [31:0] c;
    logic [31:0] addr;
    out_item_t   px;
    c = fg ? cfg_fore : cfg_back;
    addr = cur_y * cfg_line + cur_x * cfg_depth / 8;
    case (cfg_depth)
      FD_8:    px = answer(addr[OFF_BITS-1:0], {24'b0, c[7:0]}, 3'd1, ST_OK);
      FD_16:   px = answer(addr[OFF_BITS-1:0], {16'b0, c[23:19], c[15:10], c[7:3]}, 3'd2,
                           ST_OK);
      default: px = answer(addr[OFF_BITS-1:0], c, 3'd4, ST_OK);
    endcase
    px.last = 1'b0;
    return px;
  endfunction

  function automatic void next_row();
    cur_y = cur_y + 1'b1;
    cur_x = {1'b0, g_left};
    row_idx = '0;
    if (cur_y >= g_bottom) g_active = 1'b0;
  endfunction

  // works out the pixel writes (or error answer) that one accepted item causes
  function automatic void expand_item(input in_item_t it);
    out_item_t px;
    bit        gives;
    bit        frame_ok;
    int        k;
    step_px.delete();
    frame_ok = (cfg_depth == FD_8) || (cfg_depth == FD_16) || (cfg_depth == FD_32);
    if (it.command == CMD_HEADER) begin
      g_left = it.box_left;
      g_right = it.box_right_end;
      g_bottom = it.box_bottom_end;
      g_pitch = it.row_pitch;
      cur_x = {1'b0, it.box_left};
      cur_y = {1'b0, it.box_top};
      row_idx = '0;
      if (it.source_depth != SD_MONO && it.source_depth != SD_GRAY) begin
        g_active = 1'b0;
        step_px.push_back(answer('0, '0, '0, ST_BAD_GLYPH));
      end else begin
        g_gray = (it.source_depth == SD_GRAY);
        g_active = (g_right > g_left) && (g_bottom > it.box_top);
      end
    end else if (g_active) begin
      gives = g_gray || (cur_x < g_right);
      if (gives && !frame_ok) begin
        g_active = 1'b0;
        step_px.push_back(answer('0, '0, '0, ST_BAD_FRAME));
      end else if (g_gray) begin
        step_px.push_back(pixel_word(it.bitmap_byte != 8'd0));
        cur_x = cur_x + 1'b1;
        if (cur_x >= g_right) next_row();
      end else begin
        // msb is the leftmost pixel, bits past the right edge are dropped
        for (k = 7; k >= 0; k--) begin
          if (cur_x < g_right) begin
            step_px.push_back(pixel_word(it.bitmap_byte[k]));
            cur_x = cur_x + 1'b1;
          end
        end
        row_idx = row_idx + 1'b1;
        if (row_idx >= g_pitch) next_row();
      end
      if (step_px.size() > 0) begin
        px = step_px.pop_back();
        px.last = 1'b1;
        step_px.push_back(px);
      end
    end
  endfunction

  function automatic in_item_t noise_item();
    logic [95:0] junk;
    junk = {$urandom, $urandom, $urandom};
    return junk[$bits(in_item_t)-1:0];
  endfunction

  function automatic in_item_t header_item(input logic [COORD_BITS-1:0] left, top,
                                           input logic [END_BITS-1:0] right_end, bottom_end,
                                           input logic [PITCH_BITS-1:0] pitch,
                                           input logic [7:0] depth);
    in_item_t it;
    it = noise_item();
    it.command = CMD_HEADER;
    it.box_left = left;
    it.box_top = top;
    it.box_right_end = right_end;
    it.box_bottom_end = bottom_end;
    it.row_pitch = pitch;
    it.source_depth = depth;
    return it;
  endfunction

  function automatic in_item_t byte_item(input logic [7:0] b);
    in_item_t it;
    it = noise_item();
    it.command = CMD_DATA;
    it.bitmap_byte = b;
    return it;
  endfunction

  function automatic logic [7:0] byte_pick();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void plan_item(input in_item_t it);
    plan_row_t row;
    row.kind = ROW_ITEM;
    row.item = it;
    row.reg_idx = '0;
    row.reg_val = '0;
    row.typed = 1'b0;
    row.want = '0;
    plan.push_back(row);
  endfunction

  function automatic void plan_reg(input logic [CFG_IDX_BITS-1:0] idx,
                                   input logic [31:0] val);
    plan_row_t row;
    row.kind = ROW_REG;
    row.item = '0;
    row.reg_idx = idx;
    row.reg_val = val;
    row.typed = 1'b0;
    row.want = '0;
    plan.push_back(row);
  endfunction

  // fixes the single result of the last planned item by hand
  function automatic void pin(input out_item_t w);
    plan_row_t row;
    row = plan.pop_back();
    row.typed = 1'b1;
    row.want = w;
    plan.push_back(row);
  endfunction

  // one glyph: a header and its bitmap bytes, sometimes cut short or noisy
  function automatic void make_glyph();
    in_item_t h;
    int       w, hgt, pitch, nbytes, k;
    bit       gray;
    if ($urandom_range(0, 9) == 0) begin
      h = noise_item();
      h.command = CMD_HEADER;
      if ($urandom_range(0, 3) != 0) h.source_depth = $urandom_range(0, 1) ? SD_MONO : SD_GRAY;
      nbytes = $urandom_range(0, 6);
    end else begin
      gray = ($urandom_range(0, 2) == 0);
      w = $urandom_range(1, gray ? 6 : 20);
      hgt = $urandom_range(1, gray ? 3 : 4);
      pitch = (w + 7) / 8;
      case ($urandom_range(0, 7))
        0:       pitch = pitch - 1;
        1:       pitch = pitch + $urandom_range(1, 2);
        default: ;
      endcase
      h = header_item($urandom_range(0, 4095), $urandom_range(0, 4095), 0, 0, pitch,
                      gray ? SD_GRAY : SD_MONO);
      h.box_right_end = h.box_left + w;
      h.box_bottom_end = h.box_top + hgt;
      if ($urandom_range(0, 19) == 0) h.source_depth = $urandom_range(2, 7);
      nbytes = gray ? w * hgt : hgt * (pitch == 0 ? 1 : pitch);
      if ($urandom_range(0, 5) == 0) nbytes = $urandom_range(0, nbytes);
    end
    stim_q.push_back(h);
    stim_live += 1 + nbytes;
    for (k = 0; k < nbytes; k++) stim_q.push_back(byte_item(byte_pick()));
    // stray bytes once the glyph is done are dropped by the block
    if ($urandom_range(0, 7) == 0) begin
      for (k = $urandom_range(1, 3); k > 0; k--) stim_q.push_back(byte_item(byte_pick()));
    end
  endfunction

  task automatic feed(input in_item_t it, input bit more, input bit typed,
                      input out_item_t want);
    bit hold;
    hold = more && (burst_left > 1);
    in_item <= it;
    in_push <= 1'b1;
    @(posedge clk);
    while (in_full) @(posedge clk);
    if (it.command == CMD_HEADER || g_active) live_items++;
    items_sent++;
    expand_item(it);
    if (typed) pending_px.push_back(want);
    else foreach (step_px[k]) pending_px.push_back(step_px[k]);
    if (hold) begin
      burst_left--;
    end else begin
      in_push <= 1'b0;
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic settle();
    while (pending_px.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_LINE_BYTES:  cfg_line = val[LINE_BITS-1:0];
      REG_FRAME_DEPTH: cfg_depth = val[DEPTH_BITS-1:0];
      REG_FORE_COLOR:  cfg_fore = val;
      default:         cfg_back = val;
    endcase
    reg_writes++;
  endtask

  // result side: check whatever is popped, then pick the next pop
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (pending_px.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("%0t: unexpected result off=%h data=%h cnt=%0d st=%0d last=%0d", $time,
                   dut_px.byte_offset, dut_px.write_data, dut_px.byte_count, dut_px.status,
                   dut_px.last);
      end else begin
        front_px = pending_px.pop_front();
        results_checked++;
        if (dut_px.byte_offset !== front_px.byte_offset ||
            dut_px.write_data !== front_px.write_data ||
            dut_px.byte_count !== front_px.byte_count ||
            dut_px.status !== front_px.status ||
            dut_px.last !== front_px.last) begin
          fault_count++;
          if (fault_count <= 10)
            $display("%0t: got off=%h data=%h cnt=%0d st=%0d last=%0d, %s%h %s%h %s%0d %s%0d %s%0d",
                     $time, dut_px.byte_offset, dut_px.write_data, dut_px.byte_count,
                     dut_px.status, dut_px.last, "want off=", front_px.byte_offset,
                     "data=", front_px.write_data, "cnt=", front_px.byte_count,
                     "st=", front_px.status, "last=", front_px.last);
        end
      end
    end
    pop_cycle++;
    if (pop_cycle % 300 == 0) pop_mode = pop_mode_t'($urandom_range(0, 3));
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      case (pop_mode)
        POP_ALWAYS:        out_pop <= 1'b1;
        POP_THREE_IN_FOUR: out_pop <= (pop_cycle % 4) != 0;
        POP_COIN:          out_pop <= 1'($urandom_range(0, 1));
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            out_pop <= 1'b0;
          end else begin
            out_pop <= 1'b1;
            if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(3, 24);
          end
        end
      endcase
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("glyph_bitmap_pixel_expander_unit: mismatch");
    $finish;
  end

  initial begin
    int  r, phase, k, directed_items;
    bit  busy, more;
    logic [31:0] pick;

    // directed rows, starting from the reset register values
    plan_item(byte_item(8'hFF));                                  // data while idle
    plan_item(header_item(0, 0, 1, 1, 0, SD_GRAY));
    plan_item(byte_item(8'h5A));
    pin(answer(26'd0, 32'h0000_FFFF, 3'd2, ST_OK));
    plan_item(header_item(0, 0, 0, 0, 0, 8'd0));
    pin(answer('0, '0, '0, ST_BAD_GLYPH));
    plan_item(header_item(4095, 4095, 8191, 8191, 511, 8'd255));
    pin(answer('0, '0, '0, ST_BAD_GLYPH));
    plan_item(header_item(4095, 4095, 4096, 4097, 0, SD_MONO));  // zero pitch acts as one
    plan_item(byte_item(8'h80));
    plan_item(byte_item(8'h00));
    plan_item(header_item(10, 5, 10, 9, 1, SD_MONO));             // empty box
    plan_item(header_item(3, 2, 14, 4, 3, SD_MONO));
    plan_item(byte_item(8'hFF));
    plan_item(byte_item(8'hA5));
    plan_item(byte_item(8'h77));                                  // past the row width
    plan_item(header_item(0, 0, 20, 2, 1, SD_MONO));              // replaces an open glyph
    plan_item(byte_item(8'hC3));
    plan_reg(REG_FRAME_DEPTH, FD_8);
    plan_reg(REG_FORE_COLOR, 32'h1234_5678);
    plan_reg(REG_BACK_COLOR, 32'hFFFF_FFFF);
    plan_reg(REG_LINE_BYTES, 32'd1);
    plan_item(header_item(3, 2, 6, 3, 0, SD_GRAY));
    plan_item(byte_item(8'h00));
    plan_item(byte_item(8'hFF));
    plan_reg(REG_FRAME_DEPTH, FD_32);
    plan_reg(REG_LINE_BYTES, 32'd16384);
    plan_item(header_item(4095, 4095, 4096, 4096, 0, SD_GRAY));
    plan_item(byte_item(8'h01));
    pin(answer(26'h3FF_FFFC, 32'h1234_5678, 3'd4, ST_OK));
    plan_reg(REG_FRAME_DEPTH, FD_16);
    plan_item(header_item(0, 0, 4, 2, 2, SD_MONO));
    plan_item(byte_item(8'hF0));
    plan_reg(REG_FRAME_DEPTH, 32'd0);
    plan_item(byte_item(8'h55));                                  // no pixels, no error
    plan_item(byte_item(8'h55));
    pin(answer('0, '0, '0, ST_BAD_FRAME));
    plan_reg(REG_FRAME_DEPTH, 32'd63);
    plan_item(header_item(0, 0, 8, 1, 1, SD_MONO));
    plan_item(byte_item(8'h12));
    pin(answer('0, '0, '0, ST_BAD_FRAME));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    busy = 1'b0;
    for (r = 0; r < plan.size(); r++) begin
      if (plan[r].kind == ROW_REG) begin
        if (busy) begin
          settle();
          busy = 1'b0;
        end
        write_reg(plan[r].reg_idx, plan[r].reg_val);
      end else begin
        more = (r + 1 < plan.size()) && (plan[r + 1].kind == ROW_ITEM);
        feed(plan[r].item, more, plan[r].typed, plan[r].want);
        busy = 1'b1;
      end
    end
    directed_items = items_sent;

    for (phase = 0; phase < RAND_PHASES; phase++) begin
      settle();
      case ($urandom_range(0, 3))
        0:       pick = 32'd1;
        1:       pick = 32'd16384;
        2:       pick = $urandom_range(1, 16384);
        default: pick = 32'd1600;
      endcase
      write_reg(REG_LINE_BYTES, pick);
      case ($urandom_range(0, 7))
        0:       pick = $urandom_range(0, 63);
        1, 2:    pick = FD_8;
        3, 4:    pick = FD_16;
        default: pick = FD_32;
      endcase
      write_reg(REG_FRAME_DEPTH, pick);
      write_reg(REG_FORE_COLOR, $urandom);
      write_reg(REG_BACK_COLOR, $urandom);
      stim_q.delete();
      stim_live = 0;
      while (stim_live < ITEMS_PER_PHASE) make_glyph();
      for (k = 0; k < stim_q.size(); k++) feed(stim_q[k], k + 1 < stim_q.size(), 1'b0, '0);
    end

    settle();
    $display("covered %0d items (%0d directed, %0d acted on) over %0d register writes",
             items_sent, directed_items, live_items, reg_writes);
    $display("checked %0d pixel writes and error answers, %0d faults", results_checked,
             fault_count);
    if (fault_count == 0 && pending_px.size() == 0) begin
      $display("glyph_bitmap_pixel_expander_unit: match");
    end else begin
      $display("glyph_bitmap_pixel_expander_unit: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/gbpe_pkg.sv
rtl/gbpe_front.sv
rtl/gbpe_job_queue.sv
rtl/gbpe_back.sv
rtl/glyph_bitmap_pixel_expander_unit.sv
tb/tb_glyph_bitmap_pixel_expander_unit.sv
